// File: sv/aesctr_pkg.sv
// Shared AES-256 tables and round functions for the counter-mode keystream block.
// No dependencies; used by aesctr_round and aes256_ctr_keystream_xor_top.
package aesctr_pkg;

  localparam int ROUND_COUNT = 14;
  localparam int BLOCK_BYTES = 16;
  localparam int CFG_REGS    = 4;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [11] = '{
    8'h8d,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // Byte b of a 128-bit block sits at bits 127-8b down to 120-8b
  function automatic logic [127:0] sub_shift(logic [127:0] s);
    logic [127:0] t;
    int src;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = ((c + r) % 4) * 4 + r;
        t[8*(15-(c*4+r)) +: 8] = SBOX[s[8*(15-src) +: 8]];
      end
    end
    return t;
  endfunction

  function automatic logic [7:0] xtime(logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] mix_columns(logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, all;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0  = s[127-32*c -: 8];
      a1  = s[119-32*c -: 8];
      a2  = s[111-32*c -: 8];
      a3  = s[103-32*c -: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      t[127-32*c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      t[119-32*c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      t[111-32*c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[103-32*c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

  function automatic logic [31:0] sub_word(logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Slide the 8-word schedule window forward by four words
  function automatic logic [255:0] key_step(logic [255:0] win, logic [7:0] rc, logic rot);
    logic [31:0] f, n0, n1, n2, n3;
    f  = rot ? (sub_word({win[23:0], win[31:24]}) ^ {rc, 24'h0}) : sub_word(win[31:0]);
    n0 = win[255:224] ^ f;
    n1 = win[223:192] ^ n0;
    n2 = win[191:160] ^ n1;
    n3 = win[159:128] ^ n2;
    return {win[127:0], n0, n1, n2, n3};
  endfunction

endpackage

// File: sv/aes256_ctr_keystream_xor_top.sv
// AES-256 CTR byte cipher: each input byte is XORed with the next keystream byte.
// A byte inside a block is XORed and registered as it is accepted; a byte that
// needs a new block waits for load, 15 passes of the shared round unit (one per
// cycle) and output. One byte per cycle within a block while out_ready is high.
// Reset (rst, synchronous): key 0, counter 1, next byte starts a fresh block.
// Depends on aesctr_pkg and aesctr_round.
module aes256_ctr_keystream_xor_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        message_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  result_byte,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [63:0] wr_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]   state;
  logic [3:0]   rnd;
  logic [63:0]  key_bits [aesctr_pkg::CFG_REGS];
  logic [127:0] counter;
  logic [127:0] ctr_use;
  logic [127:0] ks;
  logic [127:0] aes_st;
  logic [255:0] win;
  logic [127:0] st_next;
  logic [255:0] win_next;
  logic [4:0]   offset;
  logic [7:0]   data_hold;
  logic         in_acc;
  logic         need_block;
  logic         out_free;
  logic         emit;

  assign out_free   = !out_valid || out_ready;
  assign in_ready   = (state == ST_IDLE) && out_free;
  assign in_acc     = in_valid && in_ready;
  assign need_block = message_start || offset[4];
  assign ctr_use    = message_start ? 128'd1 : counter;
  assign emit       = (in_acc && !need_block) || ((state == ST_DONE) && out_free);

  aesctr_round u_round (
    .rnd     (rnd),
    .st_in   (aes_st),
    .win_in  (win),
    .st_out  (st_next),
    .win_out (win_next)
  );

  // key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < aesctr_pkg::CFG_REGS; i++) key_bits[i] <= '0;
    end else if (wr_en && wr_index < 3'(aesctr_pkg::CFG_REGS)) begin
      key_bits[wr_index[1:0]] <= wr_data;
    end
  end

  // output word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer, counter and output word
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rnd       <= '0;
      counter   <= 128'd1;
      offset    <= 5'(aesctr_pkg::BLOCK_BYTES);
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (need_block) begin
              aes_st    <= ctr_use;
              win       <= {key_bits[0], key_bits[1], key_bits[2], key_bits[3]};
              counter   <= ctr_use + 128'd1;
              data_hold <= data_byte;
              rnd       <= '0;
              state     <= ST_RUN;
            end else begin
              result_byte <= data_byte ^ 8'(ks >> {~offset[3:0], 3'b000});
              offset      <= offset + 5'd1;
            end
          end
        end
        ST_RUN: begin
          aes_st <= st_next;
          win    <= win_next;
          if (rnd == 4'(aesctr_pkg::ROUND_COUNT)) begin
            ks    <= st_next;
            rnd   <= '0;
            state <= ST_DONE;
          end else begin
            rnd <= rnd + 4'd1;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            result_byte <= data_hold ^ ks[127:120];
            offset      <= 5'd1;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_offset_range: assert property (@(posedge clk) disable iff (rst)
    offset <= 5'(aesctr_pkg::BLOCK_BYTES))
    else $error("byte offset past block end");
  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    in_acc && message_start |=> state == ST_RUN && rnd == 4'd0)
    else $error("message start did not launch a block");
  a_run_blocks_input: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !in_ready)
    else $error("input accepted while block busy");
  a_done_offset: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && out_free |=> offset == 5'd1 && out_valid)
    else $error("fresh block did not emit its first byte");
`endif

endmodule

// File: sv/aesctr_round.sv
// One AES-256 round plus one step of the on-the-fly key schedule.
// Depends on aesctr_pkg.
module aesctr_round (
  input  logic [3:0]   rnd,
  input  logic [127:0] st_in,
  input  logic [255:0] win_in,
  output logic [127:0] st_out,
  output logic [255:0] win_out
);

  logic [127:0] rk;
  logic [127:0] ss;
  logic [3:0]   rc_idx;

  assign rk = win_in[255:128];
  assign ss = aesctr_pkg::sub_shift(st_in);

  // round r uses schedule words 4r..4r+3; new words start a rotated group on even r
  assign rc_idx  = {1'b0, rnd[3:1]} + 4'd1;
  assign win_out = aesctr_pkg::key_step(win_in, aesctr_pkg::RCON[rc_idx], ~rnd[0]);

  always_comb begin
    if (rnd == 4'd0) begin
      st_out = st_in ^ rk;
    end else if (rnd == 4'(aesctr_pkg::ROUND_COUNT)) begin
      st_out = ss ^ rk;
    end else begin
      st_out = aesctr_pkg::mix_columns(ss) ^ rk;
    end
  end

endmodule
